/* hdl/dlf_pkg.sv */
// dlf_pkg: shared types and constants for the drive link failsafe
// command codes, motor action codes, register indexes and reset values
// no dependencies
package dlf_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ACK   = 3'd1,
    CMD_DRIVE = 3'd2,
    CMD_RUN   = 3'd3,
    CMD_TEST  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_LEAVE = 2'd0,
    ACT_DRIVE = 2'd1,
    ACT_STOP  = 2'd2
  } act_t;

  localparam logic [2:0] REG_DEVICE_ID      = 3'd0;
  localparam logic [2:0] REG_BROADCAST_ID   = 3'd1;
  localparam logic [2:0] REG_WATCHDOG       = 3'd2;
  localparam logic [2:0] REG_PING_IVL       = 3'd3;
  localparam logic [2:0] REG_HELLO_IVL      = 3'd4;
  localparam logic [2:0] REG_PAIRED_HELLO   = 3'd5;
  localparam logic [2:0] REG_TEST_HOLD      = 3'd6;

  localparam logic [7:0]  RESERVED_ACK_ID     = 8'hFE;
  localparam logic [7:0]  RST_DEVICE_ID       = 8'd1;
  localparam logic [7:0]  RST_BROADCAST_ID    = 8'd255;
  localparam logic [15:0] RST_WATCHDOG        = 16'd500;
  localparam logic [15:0] RST_PING_IVL        = 16'd1000;
  localparam logic [15:0] RST_HELLO_IVL       = 16'd1000;
  localparam logic [15:0] RST_PAIRED_HELLO    = 16'd5000;
  localparam logic [15:0] RST_TEST_HOLD       = 16'd2000;

endpackage

/* hdl/drive_link_failsafe.sv */
// an accepted input beat passes the input register, then the result register, to its result beat
// throughput: one beat per cycle without out_stall; state is updated in the single pass between them
// the result register frees in the same cycle it is taken, so a stalled output only holds one item
// reset: synchronous, active low; clears pipeline valids and all link state, loads register defaults
// drive_link_failsafe: top level, depends on dlf_pkg
module drive_link_failsafe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [31:0]        in_now_ms,
  input  logic               in_length_ok,
  input  logic [7:0]         in_peer_id,
  input  logic [1:0]         in_axis_mask,
  input  logic signed [15:0] in_throttle_in,
  input  logic signed [15:0] in_steering_in,
  input  logic               in_racing_in,
  input  logic               in_sonar_cutoff,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_motor_action,
  output logic signed [15:0] out_throttle_out,
  output logic signed [15:0] out_steering_out,
  output logic               out_send_ping,
  output logic               out_send_hello,
  output logic               out_paired_out
);

  // configuration
  logic [7:0]  device_id_r, broadcast_id_r;
  logic [15:0] watchdog_r, ping_ivl_r, hello_ivl_r, paired_hello_r, test_hold_r;

  // input register
  logic               s1_vld_r;
  logic [2:0]         s1_cmd_r;
  logic [31:0]        s1_now_r;
  logic               s1_len_r;
  logic [7:0]         s1_peer_r;
  logic [1:0]         s1_mask_r;
  logic signed [15:0] s1_thr_r, s1_ste_r;
  logic               s1_race_r, s1_sonar_r;

  // link state
  logic               paired_r, racing_r;
  logic signed [15:0] held_thr_r, held_ste_r, test_thr_r, test_ste_r;
  logic [31:0]        thr_time_r, ste_time_r, test_until_r, ping_time_r, hello_time_r;

  logic               paired_nxt, racing_nxt;
  logic signed [15:0] held_thr_nxt, held_ste_nxt, test_thr_nxt, test_ste_nxt;
  logic [31:0]        thr_time_nxt, ste_time_nxt, test_until_nxt, ping_time_nxt;
  logic [31:0]        hello_time_nxt;

  // result register
  logic               out_vld_r;
  logic [1:0]         act_r;
  logic signed [15:0] othr_r, oste_r;
  logic               ping_r, hello_r, opaired_r;

  logic [1:0]         act_nxt;
  logic signed [15:0] othr_nxt, oste_nxt;
  logic               ping_nxt, hello_nxt;

  logic        advance;
  logic [31:0] thr_age, ste_age, ping_age, hello_age;
  logic [15:0] hello_ivl;

  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;

  assign thr_age   = s1_now_r - thr_time_r;
  assign ste_age   = s1_now_r - ste_time_r;
  assign ping_age  = s1_now_r - ping_time_r;
  assign hello_age = s1_now_r - hello_time_r;
  assign hello_ivl = paired_r ? paired_hello_r : hello_ivl_r;

  always_comb begin
    paired_nxt     = paired_r;
    racing_nxt     = racing_r;
    held_thr_nxt   = held_thr_r;
    held_ste_nxt   = held_ste_r;
    thr_time_nxt   = thr_time_r;
    ste_time_nxt   = ste_time_r;
    test_thr_nxt   = test_thr_r;
    test_ste_nxt   = test_ste_r;
    test_until_nxt = test_until_r;
    ping_time_nxt  = ping_time_r;
    hello_time_nxt = hello_time_r;
    act_nxt        = dlf_pkg::ACT_LEAVE;
    othr_nxt       = '0;
    oste_nxt       = '0;
    ping_nxt       = 1'b0;
    hello_nxt      = 1'b0;
    unique case (s1_cmd_r)
      dlf_pkg::CMD_TICK: begin
        if (s1_now_r < test_until_r) begin
          act_nxt  = dlf_pkg::ACT_DRIVE;
          othr_nxt = test_thr_r;
          oste_nxt = test_ste_r;
        end else if (!racing_r || thr_age > {16'd0, watchdog_r} ||
                     ste_age > {16'd0, watchdog_r} || s1_sonar_r) begin
          act_nxt = dlf_pkg::ACT_STOP;
        end
        if (paired_r && ping_age >= {16'd0, ping_ivl_r}) begin
          ping_nxt      = 1'b1;
          ping_time_nxt = s1_now_r;
        end
        if (hello_age >= {16'd0, hello_ivl}) begin
          hello_nxt      = 1'b1;
          hello_time_nxt = s1_now_r;
        end
      end
      dlf_pkg::CMD_ACK: begin
        if (s1_len_r && s1_peer_r != dlf_pkg::RESERVED_ACK_ID) begin
          paired_nxt = 1'b1;
        end
      end
      dlf_pkg::CMD_DRIVE: begin
        if (paired_r && s1_len_r && racing_r) begin
          if (s1_mask_r[0]) begin
            held_thr_nxt = s1_thr_r;
            thr_time_nxt = s1_now_r;
          end
          if (s1_mask_r[1]) begin
            held_ste_nxt = s1_ste_r;
            ste_time_nxt = s1_now_r;
          end
          if (s1_sonar_r) begin
            act_nxt = dlf_pkg::ACT_STOP;
          end else begin
            act_nxt  = dlf_pkg::ACT_DRIVE;
            othr_nxt = held_thr_nxt;
            oste_nxt = held_ste_nxt;
          end
        end
      end
      dlf_pkg::CMD_RUN: begin
        if (s1_len_r) begin
          racing_nxt = s1_race_r;
        end
      end
      dlf_pkg::CMD_TEST: begin
        if (s1_len_r && (s1_peer_r == device_id_r || s1_peer_r == broadcast_id_r)) begin
          test_thr_nxt   = s1_thr_r;
          test_ste_nxt   = s1_ste_r;
          test_until_nxt = s1_now_r + {16'd0, test_hold_r};
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r    <= dlf_pkg::RST_DEVICE_ID;
      broadcast_id_r <= dlf_pkg::RST_BROADCAST_ID;
      watchdog_r     <= dlf_pkg::RST_WATCHDOG;
      ping_ivl_r     <= dlf_pkg::RST_PING_IVL;
      hello_ivl_r    <= dlf_pkg::RST_HELLO_IVL;
      paired_hello_r <= dlf_pkg::RST_PAIRED_HELLO;
      test_hold_r    <= dlf_pkg::RST_TEST_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlf_pkg::REG_DEVICE_ID:    device_id_r    <= cfg_wdata[7:0];
        dlf_pkg::REG_BROADCAST_ID: broadcast_id_r <= cfg_wdata[7:0];
        dlf_pkg::REG_WATCHDOG:     watchdog_r     <= cfg_wdata;
        dlf_pkg::REG_PING_IVL:     ping_ivl_r     <= cfg_wdata;
        dlf_pkg::REG_HELLO_IVL:    hello_ivl_r    <= cfg_wdata;
        dlf_pkg::REG_PAIRED_HELLO: paired_hello_r <= cfg_wdata;
        dlf_pkg::REG_TEST_HOLD:    test_hold_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_cmd_r   <= in_command;
      s1_now_r   <= in_now_ms;
      s1_len_r   <= in_length_ok;
      s1_peer_r  <= in_peer_id;
      s1_mask_r  <= in_axis_mask;
      s1_thr_r   <= in_throttle_in;
      s1_ste_r   <= in_steering_in;
      s1_race_r  <= in_racing_in;
      s1_sonar_r <= in_sonar_cutoff;
    end
  end

  // link state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      paired_r     <= 1'b0;
      racing_r     <= 1'b0;
      held_thr_r   <= '0;
      held_ste_r   <= '0;
      thr_time_r   <= '0;
      ste_time_r   <= '0;
      test_thr_r   <= '0;
      test_ste_r   <= '0;
      test_until_r <= '0;
      ping_time_r  <= '0;
      hello_time_r <= '0;
    end else begin
      if (advance) begin
        out_vld_r    <= 1'b1;
        paired_r     <= paired_nxt;
        racing_r     <= racing_nxt;
        held_thr_r   <= held_thr_nxt;
        held_ste_r   <= held_ste_nxt;
        thr_time_r   <= thr_time_nxt;
        ste_time_r   <= ste_time_nxt;
        test_thr_r   <= test_thr_nxt;
        test_ste_r   <= test_ste_nxt;
        test_until_r <= test_until_nxt;
        ping_time_r  <= ping_time_nxt;
        hello_time_r <= hello_time_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (advance) begin
      act_r     <= act_nxt;
      othr_r    <= othr_nxt;
      oste_r    <= oste_nxt;
      ping_r    <= ping_nxt;
      hello_r   <= hello_nxt;
      opaired_r <= paired_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_motor_action = act_r;
  assign out_throttle_out = othr_r;
  assign out_steering_out = oste_r;
  assign out_send_ping    = ping_r;
  assign out_send_hello   = hello_r;
  assign out_paired_out   = opaired_r;

`ifndef SYNTHESIS
  // only the three defined actions leave the block
  a_act_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (act_r == dlf_pkg::ACT_LEAVE || act_r == dlf_pkg::ACT_DRIVE ||
                   act_r == dlf_pkg::ACT_STOP))
    else $error("illegal motor action");

  // drive values are zero unless driving
  a_zero_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && act_r != dlf_pkg::ACT_DRIVE |-> othr_r == 16'sd0 && oste_r == 16'sd0)
    else $error("nonzero drive values without drive action");

  // pings only go out while paired
  a_ping_paired: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ping_r |-> opaired_r)
    else $error("ping while unpaired");

  // pairing is never dropped outside reset
  a_paired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    paired_r |=> paired_r)
    else $error("pairing flag cleared");

  // state moves only when an item passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(racing_r) && $stable(test_until_r) && $stable(hello_time_r))
    else $error("link state changed without an item");
`endif

endmodule
